FILE: rtl/hpbw_pkg.sv
// Shared types, constants and header program for the I_PCM bitstream writer.
// No dependencies; used by the controller, datapath and top level.
package hpbw_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_RAW,
        OP_BITS,
        OP_UE,
        OP_ALIGN,
        OP_PIXEL
    } op_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_WIDTH,
        SRC_HEIGHT,
        SRC_SARW,
        SRC_SARH,
        SRC_TICK,
        SRC_TSCALE,
        SRC_FRAME
    } src_t;

    typedef struct packed {
        op_t         op;
        src_t        src;
        logic [19:0] value;
        logic [5:0]  len;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic cmd_ready;
        logic frame_start;
        logic mb_start;
        logic frame_end;
    } status_t;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_FPS    = 3'd2;
    localparam logic [2:0] CFG_SARW   = 3'd3;
    localparam logic [2:0] CFG_SARH   = 3'd4;
    localparam logic [2:0] CFG_TSCALE = 3'd5;

    localparam logic [5:0] IDX_SPS      = 6'd0;
    localparam logic [5:0] IDX_PPS_LAST = 6'd27;
    localparam logic [5:0] IDX_SLICE    = 6'd28;
    localparam logic [5:0] IDX_MB       = 6'd36;
    localparam logic [5:0] IDX_PIXEL    = 6'd38;
    localparam logic [5:0] IDX_STOP     = 6'd39;
    localparam logic [5:0] IDX_END      = 6'd40;

    localparam logic [7:0] EP_BYTE = 8'h03;

    // Header program: SPS, PPS, slice header, macroblock header, pixel, stop bit.
    function automatic cmd_t prog_entry(logic [5:0] idx);
        cmd_t c;
        c = '{op: OP_BITS, src: SRC_CONST, value: 20'h0, len: 6'd0, last: 1'b0};
        unique case (idx)
            6'd0, 6'd1, 6'd2, 6'd21, 6'd22, 6'd23, 6'd28, 6'd29, 6'd30: begin
                c.op = OP_RAW;
            end
            6'd3, 6'd24, 6'd31: begin
                c.op    = OP_RAW;
                c.value = 20'h1;
            end
            6'd4:  begin c.value = 20'h67;    c.len = 6'd8;  end
            6'd5:  begin c.value = 20'h42;    c.len = 6'd8;  end
            6'd6:  begin c.value = 20'h0;     c.len = 6'd8;  end
            6'd7:  begin c.value = 20'h0a;    c.len = 6'd8;  end
            6'd8:  begin c.value = 20'h1f;    c.len = 6'd5;  end
            6'd9:  begin c.value = 20'h0;     c.len = 6'd1;  end
            6'd10: begin c.op = OP_UE; c.src = SRC_WIDTH;  end
            6'd11: begin c.op = OP_UE; c.src = SRC_HEIGHT; end
            6'd12: begin c.value = 20'h13;    c.len = 6'd5;  end
            6'd13: begin c.value = 20'hff;    c.len = 6'd8;  end
            6'd14: begin c.src = SRC_SARW;    c.len = 6'd16; end
            6'd15: begin c.src = SRC_SARH;    c.len = 6'd16; end
            6'd16: begin c.value = 20'h1;     c.len = 6'd4;  end
            6'd17: begin c.src = SRC_TICK;    c.len = 6'd32; end
            6'd18: begin c.src = SRC_TSCALE;  c.len = 6'd32; end
            6'd19: begin c.value = 20'h21;    c.len = 6'd6;  end
            6'd20: c.op = OP_ALIGN;
            6'd25: begin c.value = 20'h68;    c.len = 6'd8;  end
            6'd26: begin c.value = 20'h19c71; c.len = 6'd17; end
            6'd27: begin c.op = OP_ALIGN; c.last = 1'b1; end
            6'd32: begin c.value = 20'h65;    c.len = 6'd8;  end
            6'd33: begin c.value = 20'h1110;  c.len = 6'd13; end
            6'd34: begin c.op = OP_UE; c.src = SRC_FRAME; end
            6'd35: begin c.value = 20'h1;     c.len = 6'd7;  end
            6'd36: begin c.value = 20'h1a;    c.len = 6'd9;  end
            6'd37: c.op = OP_ALIGN;
            6'd38: c.op = OP_PIXEL;
            6'd39: begin c.value = 20'h1;     c.len = 6'd1;  end
            6'd40: begin c.op = OP_ALIGN; c.last = 1'b1; end
            default: c.op = OP_ALIGN;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/h264_pcm_bitstream_writer_core.sv
// H.264 baseline I_PCM bytestream writer, top level.
// Input words are taken only while the controller is idle; a 0x03 insert adds a byte.
// The first pixel of a macroblock follows its header, and at a picture start the slice
// header too; a picture's last pixel is followed by the stop bit and alignment.
// A start word runs the tick divider, then sends the SPS and PPS commands.
// A pixel is held in the controller, then in the output word register; stalls hold.
// Synchronous active-low reset clears control state and loads register defaults.
module h264_pcm_bitstream_writer_core #(
    parameter int MAX_WIDTH_MBS  = 120,
    parameter int MAX_HEIGHT_MBS = 68,
    parameter int MB_SIZE        = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    hpbw_pkg::cmd_t    cmd;
    hpbw_pkg::status_t status;
    logic              cmd_valid;

    hpbw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_pixel   (s_pixel),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .status    (status)
    );

    hpbw_datapath #(
        .MAX_WIDTH_MBS  (MAX_WIDTH_MBS),
        .MAX_HEIGHT_MBS (MAX_HEIGHT_MBS),
        .MB_SIZE        (MB_SIZE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .status     (status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

FILE: rtl/hpbw_div.sv
// Restoring divider for the VUI tick count: tick scale over (2 * fps).
// Standalone; one quotient bit per cycle.
module hpbw_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  fps,
    output logic        busy,
    output logic [31:0] quotient
);

    logic [31:0] q_reg;
    logic [8:0]  r_reg;
    logic [8:0]  d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [9:0]  r_sh;
    logic        fit;
    logic [7:0]  fps_eff;

    assign fps_eff  = (fps == 8'd0) ? 8'd1 : fps;
    assign r_sh     = {r_reg, q_reg[31]};
    assign fit      = r_sh >= {1'b0, d_reg};
    assign busy     = busy_reg;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            q_reg    <= 32'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
            q_reg    <= dividend;
            r_reg    <= 9'd0;
            d_reg    <= {fps_eff, 1'b0};
        end else if (busy_reg) begin
            r_reg   <= fit ? 9'(r_sh - {1'b0, d_reg}) : r_sh[8:0];
            q_reg   <= {q_reg[30:0], fit};
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/hpbw_datapath.sv
// Datapath: configuration registers, bit packer, emulation prevention,
// output word register and macroblock counters. Uses hpbw_pkg and hpbw_div.
module hpbw_datapath #(
    parameter int MAX_WIDTH_MBS  = 120,
    parameter int MAX_HEIGHT_MBS = 68,
    parameter int MB_SIZE        = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               cmd_valid,
    input  hpbw_pkg::cmd_t     cmd,
    output hpbw_pkg::status_t  status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last
);

    localparam int BYTES_PER_MB = (MB_SIZE * MB_SIZE * 3) / 2;
    localparam int BW           = $clog2(BYTES_PER_MB);
    localparam logic [7:0] MAXW = 8'(MAX_WIDTH_MBS);
    localparam logic [7:0] MAXH = 8'(MAX_HEIGHT_MBS);
    localparam logic [BW-1:0] LAST_BYTE = BW'(BYTES_PER_MB - 1);

    logic [6:0]  width_reg, height_reg;
    logic [7:0]  fps_reg;
    logic [15:0] sarw_reg, sarh_reg;
    logic [31:0] tscale_reg;

    logic [8:0]    frame_reg;
    logic [6:0]    col_reg, row_reg;
    logic [BW-1:0] bmb_reg;

    logic [1:0]  zr_reg;
    logic [7:0]  m_byte_reg;
    logic        m_valid_reg, m_last_reg;
    logic [7:0]  pend_reg;
    logic        pend_valid_reg, pend_last_reg;

    logic        bw_active_reg, bw_align_reg, bw_last_reg;
    logic [31:0] bw_val_reg;
    logic [5:0]  bw_cnt_reg;
    logic [7:0]  part_reg;
    logic [2:0]  pc_reg;

    logic [7:0]  eff_w, eff_h;
    logic        col_wrap, row_wrap, frame_end;
    logic        out_free, emit_busy, div_busy, cmd_ready, cmd_fire;
    logic [31:0] src_val;
    logic [9:0]  ue_code;
    logic [3:0]  ue_msb;
    logic        bw_bit, bw_step, bw_final, bw_req;
    logic        req_valid, req_raw, req_last;
    logic [7:0]  req_byte;
    logic [31:0] tick;

    function automatic logic [1:0] zr_after(logic [1:0] zr, logic [7:0] b);
        if (b != 8'd0) begin
            return 2'd0;
        end
        return (zr == 2'd2) ? 2'd2 : zr + 2'd1;
    endfunction

    assign eff_w = (width_reg == 7'd0) ? 8'd1 :
                   (({1'b0, width_reg} > MAXW) ? MAXW : {1'b0, width_reg});
    assign eff_h = (height_reg == 7'd0) ? 8'd1 :
                   (({1'b0, height_reg} > MAXH) ? MAXH : {1'b0, height_reg});

    assign col_wrap  = ({1'b0, col_reg} + 8'd1) >= eff_w;
    assign row_wrap  = ({1'b0, row_reg} + 8'd1) >= eff_h;
    assign frame_end = (bmb_reg == LAST_BYTE) && col_wrap && row_wrap;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_busy = pend_valid_reg || !out_free;
    assign cmd_ready = !bw_active_reg && !emit_busy && !div_busy;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign status.cmd_ready   = cmd_ready;
    assign status.frame_start = (col_reg == 7'd0) && (row_reg == 7'd0);
    assign status.mb_start    = bmb_reg == '0;
    assign status.frame_end   = frame_end;

    always_comb begin
        case (cmd.src)
            hpbw_pkg::SRC_WIDTH:  src_val = {24'd0, 8'(eff_w - 8'd1)};
            hpbw_pkg::SRC_HEIGHT: src_val = {24'd0, 8'(eff_h - 8'd1)};
            hpbw_pkg::SRC_SARW:   src_val = {16'd0, sarw_reg};
            hpbw_pkg::SRC_SARH:   src_val = {16'd0, sarh_reg};
            hpbw_pkg::SRC_TICK:   src_val = tick;
            hpbw_pkg::SRC_TSCALE: src_val = tscale_reg;
            hpbw_pkg::SRC_FRAME:  src_val = {23'd0, frame_reg};
            default:              src_val = {12'd0, cmd.value};
        endcase
    end

    // ue(v): v+1 sent in 2*msb+1 bits, the leading zeros included
    always_comb begin
        ue_code = 10'(src_val[9:0] + 10'd1);
        ue_msb  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (ue_code[i]) begin
                ue_msb = 4'(i);
            end
        end
    end

    assign bw_bit   = bw_align_reg ? 1'b0 : bw_val_reg[5'(bw_cnt_reg - 6'd1)];
    assign bw_step  = bw_active_reg && !((pc_reg == 3'd7) && emit_busy);
    assign bw_final = bw_align_reg ? (pc_reg == 3'd7) : (bw_cnt_reg == 6'd1);
    assign bw_req   = bw_step && (pc_reg == 3'd7);

    always_comb begin
        req_valid = 1'b0;
        req_raw   = 1'b0;
        req_last  = 1'b0;
        req_byte  = cmd.value[7:0];
        if (bw_req) begin
            req_valid = 1'b1;
            req_byte  = {part_reg[6:0], bw_bit};
            req_last  = bw_last_reg && bw_final;
        end else if (cmd_fire && cmd.op == hpbw_pkg::OP_RAW) begin
            req_valid = 1'b1;
            req_raw   = 1'b1;
        end else if (cmd_fire && cmd.op == hpbw_pkg::OP_PIXEL) begin
            req_valid = 1'b1;
            req_last  = !frame_end;
        end
    end

    hpbw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd_fire && cmd.op == hpbw_pkg::OP_CLEAR),
        .dividend (tscale_reg),
        .fps      (fps_reg),
        .busy     (div_busy),
        .quotient (tick)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd20;
            height_reg <= 7'd15;
            fps_reg    <= 8'd25;
            sarw_reg   <= 16'd1;
            sarh_reg   <= 16'd1;
            tscale_reg <= 32'd90000;
        end else if (cfg_we) begin
            case (cfg_addr)
                hpbw_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[6:0];
                hpbw_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[6:0];
                hpbw_pkg::CFG_FPS:    fps_reg    <= cfg_wdata[7:0];
                hpbw_pkg::CFG_SARW:   sarw_reg   <= cfg_wdata[15:0];
                hpbw_pkg::CFG_SARH:   sarh_reg   <= cfg_wdata[15:0];
                hpbw_pkg::CFG_TSCALE: tscale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // output word register with one pending slot behind an inserted 0x03
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            zr_reg         <= 2'd0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && out_free) begin
                m_byte_reg     <= pend_reg;
                m_last_reg     <= pend_last_reg;
                m_valid_reg    <= 1'b1;
                pend_valid_reg <= 1'b0;
                zr_reg         <= zr_after(zr_reg, pend_reg);
            end else if (req_valid) begin
                m_valid_reg <= 1'b1;
                if (!req_raw && zr_reg == 2'd2 && req_byte <= hpbw_pkg::EP_BYTE) begin
                    m_byte_reg     <= hpbw_pkg::EP_BYTE;
                    m_last_reg     <= 1'b0;
                    pend_reg       <= req_byte;
                    pend_last_reg  <= req_last;
                    pend_valid_reg <= 1'b1;
                    zr_reg         <= 2'd0;
                end else begin
                    m_byte_reg <= req_byte;
                    m_last_reg <= req_last;
                    zr_reg     <= req_raw ? 2'd0 : zr_after(zr_reg, req_byte);
                end
            end else if (cmd_fire && cmd.op == hpbw_pkg::OP_CLEAR) begin
                zr_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_active_reg <= 1'b0;
            part_reg      <= 8'd0;
            pc_reg        <= 3'd0;
        end else if (bw_step) begin
            part_reg <= (pc_reg == 3'd7) ? 8'd0 : {part_reg[6:0], bw_bit};
            pc_reg   <= pc_reg + 3'd1;
            bw_cnt_reg <= bw_cnt_reg - 6'd1;
            if (bw_final) begin
                bw_active_reg <= 1'b0;
            end
        end else if (cmd_fire) begin
            bw_last_reg <= cmd.last;
            case (cmd.op)
                hpbw_pkg::OP_BITS: begin
                    bw_active_reg <= 1'b1;
                    bw_align_reg  <= 1'b0;
                    bw_val_reg    <= src_val;
                    bw_cnt_reg    <= cmd.len;
                end
                hpbw_pkg::OP_UE: begin
                    bw_active_reg <= 1'b1;
                    bw_align_reg  <= 1'b0;
                    bw_val_reg    <= {22'd0, ue_code};
                    bw_cnt_reg    <= 6'({ue_msb, 1'b1});
                end
                hpbw_pkg::OP_ALIGN: begin
                    bw_active_reg <= pc_reg != 3'd0;
                    bw_align_reg  <= 1'b1;
                end
                hpbw_pkg::OP_CLEAR: begin
                    part_reg <= 8'd0;
                    pc_reg   <= 3'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= 9'd0;
            col_reg   <= 7'd0;
            row_reg   <= 7'd0;
            bmb_reg   <= '0;
        end else if (cmd_fire && cmd.op == hpbw_pkg::OP_CLEAR) begin
            frame_reg <= 9'd0;
            col_reg   <= 7'd0;
            row_reg   <= 7'd0;
            bmb_reg   <= '0;
        end else if (cmd_fire && cmd.op == hpbw_pkg::OP_PIXEL) begin
            if (bmb_reg == LAST_BYTE) begin
                bmb_reg <= '0;
                if (col_wrap) begin
                    col_reg <= 7'd0;
                    if (row_wrap) begin
                        row_reg   <= 7'd0;
                        frame_reg <= frame_reg + 9'd1;
                    end else begin
                        row_reg <= row_reg + 7'd1;
                    end
                end else begin
                    col_reg <= col_reg + 7'd1;
                end
            end else begin
                bmb_reg <= bmb_reg + BW'(1);
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

FILE: rtl/hpbw_ctrl.sv
// Controller: accepts input words and steps the header program into the
// datapath as commands. Uses hpbw_pkg.
module hpbw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [7:0]         s_pixel,
    output logic               cmd_valid,
    output hpbw_pkg::cmd_t     cmd,
    input  hpbw_pkg::status_t  status
);

    typedef enum logic [1:0] {ST_IDLE, ST_CLEAR, ST_RUN} state_t;

    state_t     state_reg;
    logic [5:0] idx_reg;
    logic [7:0] pixel_reg;
    logic       fire;

    assign s_ready   = state_reg == ST_IDLE;
    assign cmd_valid = state_reg != ST_IDLE;
    assign fire      = cmd_valid && status.cmd_ready;

    always_comb begin
        cmd = hpbw_pkg::prog_entry(idx_reg);
        if (state_reg == ST_CLEAR) begin
            cmd.op = hpbw_pkg::OP_CLEAR;
        end else if (cmd.op == hpbw_pkg::OP_PIXEL) begin
            cmd.value = {12'd0, pixel_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= hpbw_pkg::IDX_SPS;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        pixel_reg <= s_pixel;
                        if (!s_opcode) begin
                            state_reg <= ST_CLEAR;
                        end else begin
                            state_reg <= ST_RUN;
                            if (status.mb_start && status.frame_start) begin
                                idx_reg <= hpbw_pkg::IDX_SLICE;
                            end else if (status.mb_start) begin
                                idx_reg <= hpbw_pkg::IDX_MB;
                            end else begin
                                idx_reg <= hpbw_pkg::IDX_PIXEL;
                            end
                        end
                    end
                end
                ST_CLEAR: begin
                    if (fire) begin
                        state_reg <= ST_RUN;
                        idx_reg   <= hpbw_pkg::IDX_SPS;
                    end
                end
                ST_RUN: begin
                    if (fire) begin
                        if (idx_reg == hpbw_pkg::IDX_PPS_LAST ||
                            idx_reg == hpbw_pkg::IDX_END) begin
                            state_reg <= ST_IDLE;
                        end else if (idx_reg == hpbw_pkg::IDX_PIXEL) begin
                            if (status.frame_end) begin
                                idx_reg <= hpbw_pkg::IDX_STOP;
                            end else begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            idx_reg <= idx_reg + 6'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
